/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* rtl/okq_pkg.sv */
package okq_pkg;
   localparam int DEPTH_DEF     = 16;
   localparam int KEY_BITS_DEF  = 32;
   localparam int DATA_BITS_DEF = 32;
   localparam int OCC_BITS      = 5;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_MATCH  = 2'd2,
      OP_PEEK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   localparam logic [0:0] REG_ORDER_MODE = 1'b0;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;
endpackage

/* rtl/ordered_key_queue.sv */
// response: an accepted request is latched, executed on the cell chain, then held valid until taken
// a new request is taken as the waiting response leaves, but not while one is executing
// all entries are compared and shifted together across the cell chain in the execute step
// reset: synchronous, active high; clears occupancy, order mode and handshake state
// entry storage is not cleared on reset
`include "assert_macros.svh"
module ordered_key_queue #(
   parameter int DEPTH     = okq_pkg::DEPTH_DEF,
   parameter int KEY_BITS  = okq_pkg::KEY_BITS_DEF,
   parameter int DATA_BITS = okq_pkg::DATA_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_op,
   input  logic [DATA_BITS-1:0] req_data_in,
   input  logic [KEY_BITS-1:0]  req_key_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [DATA_BITS-1:0] rsp_data_out,
   output logic [KEY_BITS-1:0]  rsp_key_out,
   output logic [okq_pkg::OCC_BITS-1:0] rsp_occupancy,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [0:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   okq_pkg::cmd_type      cmd;
   logic                  order_mode_ff;
   logic [CNT_BITS-1:0]   count;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) order_mode_ff <= 1'b0;
      else if (psel && penable && pwrite && paddr == okq_pkg::REG_ORDER_MODE)
         order_mode_ff <= pwdata[0];
   end
   assign pready = 1'b1;
   assign prdata = (paddr == okq_pkg::REG_ORDER_MODE) ? {31'd0, order_mode_ff} : '0;

   okq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd)
   );

   okq_datapath #(
      .DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS), .CNT_BITS(CNT_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .order_mode(order_mode_ff),
      .op(req_op), .data_in(req_data_in), .key_in(req_key_in),
      .status(rsp_status), .data_out(rsp_data_out), .key_out(rsp_key_out),
      .count(count)
   );

   assign rsp_occupancy = okq_pkg::OCC_BITS'(count);

   `ASSERT_IMPLIES(a_occ_bound, clock, reset, 1'b1, count <= CNT_BITS'(DEPTH))
   `ASSERT_NEXT(a_exec_resp, clock, reset, cmd.exec, rsp_valid)
   `ASSERT_IMPLIES(a_no_load_exec, clock, reset, cmd.exec, !cmd.load)
endmodule

/* rtl/okq_datapath.sv */
module okq_datapath #(
   parameter int DEPTH     = okq_pkg::DEPTH_DEF,
   parameter int KEY_BITS  = okq_pkg::KEY_BITS_DEF,
   parameter int DATA_BITS = okq_pkg::DATA_BITS_DEF,
   parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  okq_pkg::cmd_type       cmd,
   input  logic                   order_mode,
   input  logic [1:0]             op,
   input  logic [DATA_BITS-1:0]   data_in,
   input  logic [KEY_BITS-1:0]    key_in,
   output logic [1:0]             status,
   output logic [DATA_BITS-1:0]   data_out,
   output logic [KEY_BITS-1:0]    key_out,
   output logic [CNT_BITS-1:0]    count
);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [KEY_BITS-1:0]  keys_ff [DEPTH];
   logic [DATA_BITS-1:0] data_ff [DEPTH];
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [1:0]           op_ff;
   logic [DATA_BITS-1:0] din_ff;
   logic [KEY_BITS-1:0]  kin_ff;
   logic [1:0]           status_ff, status_in;
   logic [DATA_BITS-1:0] dout_ff, dout_in;
   logic [KEY_BITS-1:0]  kout_ff, kout_in;

   // per-cell compare flags
   logic [DEPTH-1:0] occ, gt, gt_first, hit, hit_first, ins_before, del_at_or_after;
   logic             any_hit;

   // latch the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op;
         din_ff <= data_in;
         kin_ff <= key_in;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occ[i] = CNT_BITS'(i) < count_ff;
         gt[i]  = occ[i] && (keys_ff[i] > kin_ff);
         hit[i] = occ[i] && (data_ff[i] == din_ff);
      end
      any_hit = |hit;
      // first hit and everything from it onwards, via prefix chain
      hit_first = hit & (~hit + DEPTH'(1));
      del_at_or_after = hit_first | ~(hit_first - DEPTH'(1));
      if (hit_first == '0) del_at_or_after = '0;
      // insertion: first occupied cell with a strictly greater key, and all held cells after it
      gt_first   = gt & (~gt + DEPTH'(1));
      ins_before = order_mode ? ((gt_first | ~(gt_first - DEPTH'(1))) & occ) : '0;
   end

   // result selection and count update
   always_comb begin
      status_in = okq_pkg::ST_OK;
      dout_in   = '0;
      kout_in   = '0;
      count_in  = count_ff;
      case (okq_pkg::op_type'(op_ff))
         okq_pkg::OP_ADD: begin
            if (count_ff >= FULL_CNT) status_in = okq_pkg::ST_FULL;
            else count_in = count_ff + CNT_BITS'(1);
         end
         okq_pkg::OP_MATCH: begin
            if (count_ff == '0) status_in = okq_pkg::ST_EMPTY;
            else if (!any_hit) status_in = okq_pkg::ST_NOTFOUND;
            else begin
               count_in = count_ff - CNT_BITS'(1);
               dout_in  = din_ff;
               for (int i = 0; i < DEPTH; i++)
                  if (hit_first[i]) kout_in = kout_in | keys_ff[i];
            end
         end
         default: begin
            if (count_ff == '0) status_in = okq_pkg::ST_EMPTY;
            else begin
               dout_in = data_ff[0];
               kout_in = keys_ff[0];
               if (op_ff == okq_pkg::OP_REMOVE) count_in = count_ff - CNT_BITS'(1);
            end
         end
      endcase
   end

   // shift-register cell chain
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         dout_ff   <= dout_in;
         kout_ff   <= kout_in;
         for (int i = 0; i < DEPTH; i++) begin
            if (op_ff == okq_pkg::OP_ADD && count_ff < FULL_CNT) begin
               if (ins_before[i]) begin
                  if (i == 0 || !ins_before[(i == 0) ? 0 : i-1]) begin
                     keys_ff[i] <= kin_ff;
                     data_ff[i] <= din_ff;
                  end else begin
                     keys_ff[i] <= keys_ff[(i == 0) ? 0 : i-1];
                     data_ff[i] <= data_ff[(i == 0) ? 0 : i-1];
                  end
               end else if (CNT_BITS'(i) == count_ff) begin
                  if (i != 0 && ins_before[(i == 0) ? 0 : i-1]) begin
                     keys_ff[i] <= keys_ff[(i == 0) ? 0 : i-1];
                     data_ff[i] <= data_ff[(i == 0) ? 0 : i-1];
                  end else begin
                     keys_ff[i] <= kin_ff;
                     data_ff[i] <= din_ff;
                  end
               end
            end else if (count_ff != '0 && i < DEPTH-1 &&
                         ((op_ff == okq_pkg::OP_REMOVE) ||
                          (op_ff == okq_pkg::OP_MATCH && del_at_or_after[i]))) begin
               keys_ff[i] <= keys_ff[(i < DEPTH-1) ? i+1 : i];
               data_ff[i] <= data_ff[(i < DEPTH-1) ? i+1 : i];
            end
         end
      end
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign status   = status_ff;
   assign data_out = dout_ff;
   assign key_out  = kout_ff;
   assign count    = count_ff;
endmodule

/* rtl/okq_ctrl.sv */
module okq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output okq_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = req_valid ? S_EXEC : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // a request is taken when idle, or as the waiting response leaves
   assign req_stall = !((state_ff == S_IDLE) || (state_ff == S_RESP && !rsp_stall));
   assign rsp_valid = state_ff == S_RESP;
   assign cmd.load  = req_valid && !req_stall;
   assign cmd.exec  = state_ff == S_EXEC;
endmodule

/* dv/tb_ordered_key_queue.sv */
`timescale 1ns / 100ps
module tb_ordered_key_queue;
   localparam int QDEPTH = okq_pkg::DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = okq_pkg::OP_PEEK;
   logic [31:0] req_data_in = '0;
   logic [31:0] req_key_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_data_out;
   logic [31:0] rsp_key_out;
   logic [okq_pkg::OCC_BITS-1:0] rsp_occupancy;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [0:0]  paddr = okq_pkg::REG_ORDER_MODE;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   typedef struct packed {
      okq_pkg::op_type op;
      logic [31:0]     data;
      logic [31:0]     key;
   } request_type;

   typedef struct packed {
      okq_pkg::status_type          status;
      logic [31:0]                  data;
      logic [31:0]                  key;
      logic [okq_pkg::OCC_BITS-1:0] occ;
   } response_type;

   ordered_key_queue i_dut (.*);

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        error_count = 0;
   int        cycle_count = 0;
   int        requests_sent = 0;
   int        responses_seen = 0;

   // shadow queue contents and mode
   logic [31:0] shadow_keys[QDEPTH];
   logic [31:0] shadow_data[QDEPTH];
   int          shadow_count = 0;
   logic        shadow_ordered = 1'b0;

   function automatic response_type predict_queue_op(request_type r);
      response_type rsp;
      int pos;
      rsp = '{status: okq_pkg::ST_OK, data: '0, key: '0, occ: '0};
      if (r.op == okq_pkg::OP_ADD) begin
         if (shadow_count >= QDEPTH) begin
            rsp.status = okq_pkg::ST_FULL;
         end else begin
            pos = shadow_count;
            if (shadow_ordered) begin
               pos = 0;
               while (pos < shadow_count && r.key >= shadow_keys[pos]) pos++;
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_data[i] = shadow_data[i-1];
            end
            shadow_keys[pos] = r.key;
            shadow_data[pos] = r.data;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         rsp.status = okq_pkg::ST_EMPTY;
      end else begin
         pos = 0;
         if (r.op == okq_pkg::OP_MATCH)
            while (pos < shadow_count && shadow_data[pos] != r.data) pos++;
         if (pos >= shadow_count) begin
            rsp.status = okq_pkg::ST_NOTFOUND;
         end else begin
            rsp.data = shadow_data[pos];
            rsp.key  = shadow_keys[pos];
            if (r.op != okq_pkg::OP_PEEK) begin
               for (int i = pos; i + 1 < shadow_count; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_data[i] = shadow_data[i+1];
               end
               shadow_count--;
            end
         end
      end
      rsp.occ = shadow_count[okq_pkg::OCC_BITS-1:0];
      return rsp;
   endfunction

   // request driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_responses.push_back(predict_queue_op({req_op, req_data_in, req_key_in}));
            requests_sent++;
         end
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            request_type r;
            r = pending_requests.pop_front();
            req_valid   <= 1'b1;
            req_op      <= r.op;
            req_data_in <= r.data;
            req_key_in  <= r.key;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               response_type e;
               e = expected_responses.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  error_count++;
               end
               if (rsp_data_out !== e.data) begin
                  $error("data_out: expected %h, got %h", e.data, rsp_data_out);
                  error_count++;
               end
               if (rsp_key_out !== e.key) begin
                  $error("key_out: expected %h, got %h", e.key, rsp_key_out);
                  error_count++;
               end
               if (rsp_occupancy !== e.occ) begin
                  $error("occupancy: expected %0d, got %0d", e.occ, rsp_occupancy);
                  error_count++;
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // timeout
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic write_order_mode(input logic mode);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= okq_pkg::REG_ORDER_MODE;
      pwdata <= {$urandom_range(1) ? 31'h7fffffff : 31'h0, mode};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      shadow_ordered = mode;
   endtask

   task automatic drain_queue();
      while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word(int small_pool);
      case ($urandom_range(5))
         0: return 32'hffffffff;
         1: return 32'h0;
         2, 3: return $urandom_range(small_pool);
         default: return $urandom;
      endcase
   endfunction

   // adds weighted up; keys and data partly from small pools to hit equal keys and matches
   task automatic queue_random_requests(int n);
      request_type r;
      for (int i = 0; i < n; i++) begin
         r.op   = okq_pkg::op_type'($urandom_range(3));
         if ($urandom_range(9) < 3) r.op = okq_pkg::OP_ADD;
         r.data = pick_word(20);
         r.key  = pick_word(8);
         pending_requests.push_back(r);
      end
   endtask

   task automatic queue_request(okq_pkg::op_type op, logic [31:0] data, logic [31:0] key);
      pending_requests.push_back('{op: op, data: data, key: key});
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, fill to full, match hit and miss, extremes
      queue_request(okq_pkg::OP_REMOVE, 32'h0, 32'h0);
      queue_request(okq_pkg::OP_PEEK, 32'h0, 32'h0);
      queue_request(okq_pkg::OP_MATCH, 32'h5, 32'h0);
      for (int i = 0; i < 17; i++)
         queue_request(okq_pkg::OP_ADD, i == 0 ? 32'hffffffff : i,
                       i == 1 ? 32'hffffffff : 16 - i);
      queue_request(okq_pkg::OP_PEEK, 32'h0, 32'h0);
      queue_request(okq_pkg::OP_MATCH, 32'h7, 32'h0);
      queue_request(okq_pkg::OP_MATCH, 32'h12345678, 32'h0);
      queue_request(okq_pkg::OP_REMOVE, 32'h0, 32'h0);
      drain_queue();

      // ordered mode with equal keys
      write_order_mode(1'b1);
      for (int i = 0; i < 20; i++) queue_request(okq_pkg::OP_REMOVE, 32'h0, 32'h0);
      queue_request(okq_pkg::OP_ADD, 32'ha, 32'h5);
      queue_request(okq_pkg::OP_ADD, 32'hb, 32'h5);
      queue_request(okq_pkg::OP_ADD, 32'hc, 32'h0);
      queue_request(okq_pkg::OP_ADD, 32'hd, 32'hffffffff);
      queue_request(okq_pkg::OP_ADD, 32'he, 32'h5);
      drain_queue();

      send_idle_pct = 33; recv_idle_pct = 58;
      queue_random_requests(220);
      drain_queue();
      write_order_mode(1'b0);

      send_idle_pct = 58; recv_idle_pct = 33;
      queue_random_requests(220);
      drain_queue();
      write_order_mode(1'b1);

      send_idle_pct = 0; recv_idle_pct = 0;
      queue_random_requests(200);
      drain_queue();

      $display("sent %0d requests, checked %0d responses, both insertion modes",
               requests_sent, responses_seen);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
